/* rtl/cdw_pkg.sv */
package cdw_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_LOAD_PIX  = 2'd0,
    OP_LOAD_CELL = 2'd1,
    OP_WARP      = 2'd2,
    OP_RESERVED  = 2'd3
  } op_e;

  // Field widths of the stream payloads
  localparam int unsigned OP_W        = 2;
  localparam int unsigned POS_X_W     = 9;
  localparam int unsigned POS_Y_W     = 8;
  localparam int unsigned RGB_W       = 24;
  localparam int unsigned SHIFT_W     = 16;
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 24;

  // Per-channel displacement scale, Q.10
  localparam int unsigned K_FRAC  = 10;
  localparam int unsigned K_RED   = 768;
  localparam int unsigned K_GREEN = 896;
  localparam int unsigned K_BLUE  = 1024;

  // Default geometry
  localparam int unsigned FRAME_WIDTH_DEF     = 512;
  localparam int unsigned FRAME_HEIGHT_DEF    = 256;
  localparam int unsigned CELL_SIZE_DEF       = 4;
  localparam int unsigned SHIFT_FRAC_BITS_DEF = 8;

endpackage

/* rtl/chromatic_displacement_warp_unit.sv */
// Chromatic displacement warp.
// Input stream (s_axis): one beat per item. tuser selects the kind: load one
// source pixel into the three color planes, load one cell's displacement
// vector, or warp one destination pixel. Loads produce no output beat.
// Output stream (m_axis): one beat per warp, carrying the warped pixel and a
// flag telling whether the chromatic sample was added.
// Throughput: one item per cycle while m_axis does not stall. Each item
// makes at most one access to the cell memory and one to each plane memory,
// each on its own single port, so nothing is shared between consecutive items.
// A warp passes the cell read, coordinate compute, plane read and saturating
// add stages, then the output register that drives m_axis.
// Loads write the memory at the same pipeline stage where warps read it, so
// every item sees exactly the loads accepted before it.
// Stall: the pipeline advances only while the output register is empty or
// being taken; s_axis_tready follows that, so a stalled receiver freezes all
// stages and holds the pending beat. Reset clears the stage valid bits and the
// output beat; memory contents stay undefined until loaded.
module chromatic_displacement_warp_unit #(
  parameter int unsigned FRAME_WIDTH     = cdw_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT    = cdw_pkg::FRAME_HEIGHT_DEF,
  parameter int unsigned CELL_SIZE       = cdw_pkg::CELL_SIZE_DEF,
  parameter int unsigned SHIFT_FRAC_BITS = cdw_pkg::SHIFT_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_x[8:0], pos_y[16:9], pixel_rgb[40:17], shift_x[56:41], shift_y[72:57]
  input  logic [cdw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // operation[1:0]
  input  logic [cdw_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // result_rgb[23:0]
  output logic [cdw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // was_changed[0]
  output logic                               m_axis_tuser
);
  import cdw_pkg::*;

  localparam int unsigned GridW     = (FRAME_WIDTH + CELL_SIZE - 1) / CELL_SIZE;
  localparam int unsigned GridH     = (FRAME_HEIGHT + CELL_SIZE - 1) / CELL_SIZE;
  localparam int unsigned CellCount = GridW * GridH;
  localparam int unsigned PixCount  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned CellAW    = (CellCount > 1) ? $clog2(CellCount) : 1;
  localparam int unsigned PixAW     = $clog2(PixCount);
  localparam int unsigned XW        = $clog2(FRAME_WIDTH);
  localparam int unsigned YW        = $clog2(FRAME_HEIGHT);
  localparam int unsigned LimW      = (XW > YW) ? XW : YW;
  localparam int unsigned QW        = (LimW + 1 > 13) ? LimW + 1 : 13;
  localparam int unsigned Acc       = SHIFT_FRAC_BITS + K_FRAC;
  localparam int unsigned TW        = QW + Acc + 1;
  localparam int unsigned Half      = 2 ** (Acc - 1);
  // Cell index by reciprocal multiply; exact for any position of the field width
  localparam int unsigned CxSh      = POS_X_W + 4;
  localparam int unsigned CySh      = POS_Y_W + 4;
  localparam int unsigned CxM       = (2 ** CxSh + CELL_SIZE - 1) / CELL_SIZE;
  localparam int unsigned CyM       = (2 ** CySh + CELL_SIZE - 1) / CELL_SIZE;
  localparam int unsigned CxPW      = POS_X_W + CxSh + 1;
  localparam int unsigned CyPW      = POS_Y_W + CySh + 1;

  logic en;

  // Input field split
  logic [POS_X_W-1:0] in_px;
  logic [POS_Y_W-1:0] in_py;
  logic [RGB_W-1:0]   in_rgb;
  logic [SHIFT_W-1:0] in_sx;
  logic [SHIFT_W-1:0] in_sy;
  logic [CxPW-1:0]    cx_prod;
  logic [CyPW-1:0]    cy_prod;

  assign in_px  = s_axis_tdata[8:0];
  assign in_py  = s_axis_tdata[16:9];
  assign in_rgb = s_axis_tdata[40:17];
  assign in_sx  = s_axis_tdata[56:41];
  assign in_sy  = s_axis_tdata[72:57];

  assign cx_prod = CxPW'(in_px) * CxPW'(CxM);
  assign cy_prod = CyPW'(in_py) * CyPW'(CyM);

  // Stage 1: accepted item and its cell index
  logic                v1_q;
  logic [OP_W-1:0]     op1_q;
  logic [POS_X_W-1:0]  px1_q;
  logic [POS_Y_W-1:0]  py1_q;
  logic [RGB_W-1:0]    rgb1_q;
  logic [SHIFT_W-1:0]  sx1_q;
  logic [SHIFT_W-1:0]  sy1_q;
  logic [POS_X_W-1:0]  cx1_q;
  logic [POS_Y_W-1:0]  cy1_q;
  logic                pix_in1_q;
  logic                cell_in1_q;

  // Stage 2: cell vector read back
  logic                v2_q;
  logic [OP_W-1:0]     op2_q;
  logic [POS_X_W-1:0]  px2_q;
  logic [POS_Y_W-1:0]  py2_q;
  logic [RGB_W-1:0]    rgb2_q;
  logic                pix_in2_q;
  logic [2*SHIFT_W-1:0] cell_rd_q;

  // Stage 3: sample coordinates
  logic                v3_q;
  logic [OP_W-1:0]     op3_q;
  logic [POS_X_W-1:0]  px3_q;
  logic [POS_Y_W-1:0]  py3_q;
  logic [RGB_W-1:0]    rgb3_q;
  logic                pix_in3_q;
  logic                ok3_q;
  logic [LimW-1:0]     coord_q [6];

  // Stage 4: plane samples
  logic                v4_q;
  logic [OP_W-1:0]     op4_q;
  logic [RGB_W-1:0]    rgb4_q;
  logic                ok4_q;
  logic [7:0]          red_rd_q;
  logic [7:0]          green_rd_q;
  logic [7:0]          blue_rd_q;

  // Output register
  logic                out_valid_q;
  logic [RGB_W-1:0]    out_rgb_q;
  logic                out_changed_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_rgb_q;
  assign m_axis_tuser  = out_changed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= s_axis_tvalid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q && (op4_q == OP_WARP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q      <= s_axis_tuser;
      px1_q      <= in_px;
      py1_q      <= in_py;
      rgb1_q     <= in_rgb;
      sx1_q      <= in_sx;
      sy1_q      <= in_sy;
      cx1_q      <= cx_prod[CxSh +: POS_X_W];
      cy1_q      <= cy_prod[CySh +: POS_Y_W];
      pix_in1_q  <= (32'(in_px) < FRAME_WIDTH) && (32'(in_py) < FRAME_HEIGHT);
      cell_in1_q <= (32'(in_px) < GridW) && (32'(in_py) < GridH);
    end
  end

  // Cell memory: vector loads write and warps read at the same stage
  logic [2*SHIFT_W-1:0] cell_mem [CellCount];
  logic [CellAW-1:0]    cell_addr;
  logic [POS_X_W-1:0]   cell_col;
  logic [POS_Y_W-1:0]   cell_row;
  logic                 cell_we;

  always_comb begin
    if (op1_q == OP_LOAD_CELL) begin
      cell_col = px1_q;
      cell_row = py1_q;
    end else begin
      cell_col = cx1_q;
      cell_row = cy1_q;
    end
  end

  assign cell_addr = CellAW'(32'(cell_row) * GridW + 32'(cell_col));
  assign cell_we   = v1_q && (op1_q == OP_LOAD_CELL) && cell_in1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (cell_we) begin
        cell_mem[cell_addr] <= {sy1_q, sx1_q};
      end
      cell_rd_q <= cell_mem[cell_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q     <= op1_q;
      px2_q     <= px1_q;
      py2_q     <= py1_q;
      rgb2_q    <= rgb1_q;
      pix_in2_q <= pix_in1_q;
    end
  end

  // Sample lanes: even lanes are x, odd lanes are y; red, green, blue in pairs
  logic [POS_X_W-1:0]        lane_p  [6];
  logic signed [SHIFT_W-1:0] lane_d  [6];
  logic                      lane_ok [6];
  logic [LimW-1:0]           lane_c  [6];

  for (genvar i = 0; i < 6; i++) begin : g_lane
    localparam int unsigned K   = (i < 2) ? K_RED : ((i < 4) ? K_GREEN : K_BLUE);
    localparam int unsigned Lim = (i % 2 == 0) ? FRAME_WIDTH : FRAME_HEIGHT;

    logic signed [TW-1:0] t;
    logic [QW-1:0]        q;
    logic                 neg_in;

    if (i % 2 == 0) begin : g_x
      assign lane_p[i] = px2_q;
      assign lane_d[i] = $signed(cell_rd_q[SHIFT_W-1:0]);
    end else begin : g_y
      assign lane_p[i] = POS_X_W'(py2_q);
      assign lane_d[i] = $signed(cell_rd_q[2*SHIFT_W-1:SHIFT_W]);
    end

    // p + 1/2 - d*k with Acc fraction bits
    assign t = $signed(TW'(lane_p[i]) << Acc) + $signed(TW'(Half))
             - TW'(lane_d[i]) * $signed(TW'(K));
    assign q = t[TW-2:Acc];
    // a value in (-1, 0) truncates to zero and still counts as inside
    assign neg_in = (&t[TW-1:Acc]) && (|t[Acc-1:0]);
    assign lane_ok[i] = t[TW-1] ? neg_in : (q < QW'(Lim));
    assign lane_c[i]  = t[TW-1] ? '0 : q[LimW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op3_q     <= op2_q;
      px3_q     <= px2_q;
      py3_q     <= py2_q;
      rgb3_q    <= rgb2_q;
      pix_in3_q <= pix_in2_q;
      ok3_q     <= pix_in2_q && lane_ok[0] && lane_ok[1] && lane_ok[2]
                && lane_ok[3] && lane_ok[4] && lane_ok[5];
      for (int j = 0; j < 6; j++) begin
        coord_q[j] <= lane_c[j];
      end
    end
  end

  // Plane memories: pixel loads write and warps read at the same stage
  logic [7:0]       red_mem   [PixCount];
  logic [7:0]       green_mem [PixCount];
  logic [7:0]       blue_mem  [PixCount];
  logic [PixAW-1:0] load_addr;
  logic [PixAW-1:0] red_addr;
  logic [PixAW-1:0] green_addr;
  logic [PixAW-1:0] blue_addr;
  logic             pix_we;

  assign load_addr  = PixAW'(32'(py3_q) * FRAME_WIDTH + 32'(px3_q));
  assign red_addr   = PixAW'(32'(coord_q[1][YW-1:0]) * FRAME_WIDTH
                    + 32'(coord_q[0][XW-1:0]));
  assign green_addr = PixAW'(32'(coord_q[3][YW-1:0]) * FRAME_WIDTH
                    + 32'(coord_q[2][XW-1:0]));
  assign blue_addr  = PixAW'(32'(coord_q[5][YW-1:0]) * FRAME_WIDTH
                    + 32'(coord_q[4][XW-1:0]));
  assign pix_we     = v3_q && (op3_q == OP_LOAD_PIX) && pix_in3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pix_we) begin
        red_mem[load_addr]   <= rgb3_q[23:16];
        green_mem[load_addr] <= rgb3_q[15:8];
        blue_mem[load_addr]  <= rgb3_q[7:0];
      end
      red_rd_q   <= red_mem[red_addr];
      green_rd_q <= green_mem[green_addr];
      blue_rd_q  <= blue_mem[blue_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op4_q  <= op3_q;
      rgb4_q <= rgb3_q;
      ok4_q  <= ok3_q;
    end
  end

  // Saturating add of each sample onto the destination pixel
  logic [8:0]       sum_r;
  logic [8:0]       sum_g;
  logic [8:0]       sum_b;
  logic [RGB_W-1:0] warped;

  assign sum_r  = {1'b0, rgb4_q[23:16]} + {1'b0, red_rd_q};
  assign sum_g  = {1'b0, rgb4_q[15:8]} + {1'b0, green_rd_q};
  assign sum_b  = {1'b0, rgb4_q[7:0]} + {1'b0, blue_rd_q};
  assign warped = {sum_r[8] ? 8'hFF : sum_r[7:0],
                   sum_g[8] ? 8'hFF : sum_g[7:0],
                   sum_b[8] ? 8'hFF : sum_b[7:0]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_rgb_q     <= ok4_q ? warped : rgb4_q;
      out_changed_q <= ok4_q;
    end
  end

  // A new output beat only ever comes from a warp in the last stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(v4_q && (op4_q == OP_WARP)))
    else $error("output beat without a warp in the last stage");

  // A load leaving the last stage drops out without a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v4_q && (op4_q != OP_WARP) |=> !m_axis_tvalid)
    else $error("load produced an output beat");

  // A warp leaving the last stage always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v4_q && (op4_q == OP_WARP) |=> m_axis_tvalid)
    else $error("warp lost at the output register");

  // While the receiver stalls, the whole pipeline holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v4_q) && $stable(v1_q))
    else $error("pipeline advanced during a stall");

endmodule
